[hw/rtl/ffca_pkg.sv]
// Shared types and constants for the first-fit chunk allocator.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package ffca_pkg;

   // pool geometry
   localparam int POOL_CHUNKS = 1024;
   localparam int CHUNK_BYTES = 16;
   localparam int ADDR_W      = $clog2(POOL_CHUNKS);
   localparam int IDX_W       = ADDR_W + 1;
   localparam int SUM_W       = IDX_W + 1;
   localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);
   localparam int FIELD_W     = 14;
   localparam int BYTE_W      = IDX_W + CHUNK_SHIFT;
   localparam int WORD_W      = 2 * IDX_W;

   localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(POOL_CHUNKS);

   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic [1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_RESIZE = 2'd2,
      CMD_QUERY  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_SPACE  = 2'd1,
      ST_BAD_ADDR  = 2'd2,
      ST_NOT_READY = 2'd3
   } status_type;

   // datapath micro-operations, one per cycle
   typedef enum logic [5:0] {
      DP_NOP,
      DP_LATCH,
      DP_INIT_POOL,
      DP_LOC_RD,
      DP_LOC_HDR,
      DP_WALK_INIT,
      DP_WALK_RD,
      DP_NB_STEP,
      DP_FF_INIT,
      DP_FF_STEP,
      DP_GROW_INIT,
      DP_LATCH_C,
      DP_TAKE1,
      DP_TAKE2,
      DP_TAKE3,
      DP_GROW_CLR,
      DP_GROW_H,
      DP_SHR_WR,
      DP_SHR_FIN,
      DP_RES_ALLOC,
      DP_RES_MOVE,
      DP_RES_SAME,
      DP_RES_QUERY,
      DP_INS_PUT_H,
      DP_INS_PREV,
      DP_INS_AFT,
      DP_INS_AFT_CLR,
      DP_INS_PRV,
      DP_INS_PRV_CLR,
      DP_ST_BAD,
      DP_ST_NOSPACE,
      DP_ST_NOTREADY,
      DP_EMIT
   } dp_op_type;

   // datapath status toward the controller
   typedef struct packed {
      cmd_type cmd;
      logic    pool_ready;
      logic    loc_bad_addr;
      logic    hdr_bad;
      logic    walk_nb_go;
      logic    walk_ff_go;
      logic    nb_ok;
      logic    grow_hit;
      logic    fit;
      logic    need_eq;
      logic    need_lt;
      logic    merge_after;
      logic    merge_prev;
   } dp_flags_type;

endpackage

[hw/rtl/ffca_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ffca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/ffca_dp.sv]
// Datapath of the allocator: list walk registers, header store, results.
// Depends on ffca_pkg and ffca_ram; driven by micro-operations from ffca_ctrl.
`timescale 1ns / 1ps

module ffca_dp
   import ffca_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  dp_op_type          op,
   input  logic [1:0]         req_cmd,
   input  logic [FIELD_W-1:0] req_size_bytes,
   input  logic [FIELD_W-1:0] req_address,
   output dp_flags_type       flags,
   output logic [FIELD_W-1:0] rsp_result_address,
   output logic [FIELD_W-1:0] rsp_result_size,
   output logic               rsp_moved,
   output logic [1:0]         rsp_status
);

   // transaction payload
   cmd_type            cmd_ff, cmd_in;
   logic [FIELD_W-1:0] size_ff, size_in;
   logic [FIELD_W-1:0] addr_ff, addr_in;
   idx_type            need_ff, need_in;
   // reservation under work and insert target
   idx_type            h_ff, h_in;
   idx_type            len_ff, len_in;
   idx_type            tgt_h_ff, tgt_h_in;
   idx_type            tgt_len_ff, tgt_len_in;
   // list walk
   idx_type            p_ff, p_in;
   idx_type            p_len_ff, p_len_in;
   idx_type            cur_ff, cur_in;
   idx_type            steps_ff, steps_in;
   idx_type            c_len_ff, c_len_in;
   idx_type            c_link_ff, c_link_in;
   idx_type            take_n_ff, take_n_in;
   idx_type            nxt_ff, nxt_in;
   idx_type            ins_link_ff, ins_link_in;
   // pool state
   idx_type            free_head_ff, free_head_in;
   logic               pool_ready_ff, pool_ready_in;
   // results
   logic [FIELD_W-1:0] r_addr_ff, r_addr_in;
   logic [FIELD_W-1:0] r_size_ff, r_size_in;
   logic               r_moved_ff, r_moved_in;
   status_type         r_status_ff, r_status_in;
   logic [FIELD_W-1:0] out_addr_ff, out_addr_in;
   logic [FIELD_W-1:0] out_size_ff, out_size_in;
   logic               out_moved_ff, out_moved_in;
   status_type         out_status_ff, out_status_in;

   // header store port
   logic               wr_req;
   idx_type            wr_idx;
   idx_type            wr_len;
   idx_type            wr_link;
   logic               wr_en;
   idx_type            rd_idx;
   logic [WORD_W-1:0]  rd_word;
   idx_type            rd_len;
   idx_type            rd_link;

   // derived values
   logic [FIELD_W-1:0] chunk_full;
   idx_type            hh;
   idx_type            after;
   logic [FIELD_W:0]   need_sum;
   logic [FIELD_W:0]   need_q;
   idx_type            req_need;
   logic [BYTE_W-1:0]  cur_bytes;
   logic [BYTE_W-1:0]  old_bytes;
   logic [SUM_W-1:0]   p_end;
   logic [SUM_W-1:0]   tgt_end;

   assign rd_len  = rd_word[WORD_W-1:IDX_W];
   assign rd_link = rd_word[IDX_W-1:0];

   // address decode and rounding
   assign chunk_full = addr_ff >> CHUNK_SHIFT;
   assign hh         = IDX_W'(chunk_full - FIELD_W'(1));
   assign after      = (cur_ff > NULL_IDX) ? NULL_IDX : cur_ff;
   assign need_sum   = (FIELD_W + 1)'(req_size_bytes) + (FIELD_W + 1)'(CHUNK_BYTES - 1);
   assign need_q     = need_sum >> CHUNK_SHIFT;
   assign req_need   = IDX_W'(need_q) + IDX_W'(1);
   assign cur_bytes  = BYTE_W'(cur_ff + IDX_W'(1)) << CHUNK_SHIFT;
   assign old_bytes  = BYTE_W'(len_ff - IDX_W'(1)) << CHUNK_SHIFT;
   assign p_end      = SUM_W'(p_ff) + SUM_W'(p_len_ff);
   assign tgt_end    = SUM_W'(tgt_h_ff) + SUM_W'(tgt_len_ff);

   // status toward the controller
   always_comb begin
      flags.cmd          = cmd_ff;
      flags.pool_ready   = pool_ready_ff;
      flags.loc_bad_addr = (chunk_full == '0) || (chunk_full >= FIELD_W'(POOL_CHUNKS));
      flags.hdr_bad      = (rd_len == '0) || (rd_len > (NULL_IDX - hh)) ||
                           (rd_link != (hh + IDX_W'(1)));
      flags.walk_nb_go   = (cur_ff < tgt_h_ff) && (steps_ff < NULL_IDX);
      flags.walk_ff_go   = (cur_ff < NULL_IDX) && (steps_ff < NULL_IDX);
      flags.nb_ok        = !((p_ff != NULL_IDX) && (p_end > SUM_W'(tgt_h_ff))) &&
                           !((after != NULL_IDX) && (SUM_W'(after) < tgt_end));
      flags.grow_hit     = (cur_ff == tgt_h_ff) && (cur_ff < NULL_IDX);
      flags.fit          = (rd_len >= take_n_ff);
      flags.need_eq      = (need_ff == len_ff);
      flags.need_lt      = (need_ff < len_ff);
      flags.merge_after  = (after != NULL_IDX) && (tgt_end == SUM_W'(after));
      flags.merge_prev   = (p_ff != NULL_IDX) && (p_end == SUM_W'(tgt_h_ff));
   end

   // micro-operation decode
   always_comb begin
      cmd_in        = cmd_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      need_in       = need_ff;
      h_in          = h_ff;
      len_in        = len_ff;
      tgt_h_in      = tgt_h_ff;
      tgt_len_in    = tgt_len_ff;
      p_in          = p_ff;
      p_len_in      = p_len_ff;
      cur_in        = cur_ff;
      steps_in      = steps_ff;
      c_len_in      = c_len_ff;
      c_link_in     = c_link_ff;
      take_n_in     = take_n_ff;
      nxt_in        = nxt_ff;
      ins_link_in   = ins_link_ff;
      free_head_in  = free_head_ff;
      pool_ready_in = pool_ready_ff;
      r_addr_in     = r_addr_ff;
      r_size_in     = r_size_ff;
      r_moved_in    = r_moved_ff;
      r_status_in   = r_status_ff;
      out_addr_in   = out_addr_ff;
      out_size_in   = out_size_ff;
      out_moved_in  = out_moved_ff;
      out_status_in = out_status_ff;
      wr_req        = 1'b0;
      wr_idx        = cur_ff;
      wr_len        = '0;
      wr_link       = '0;
      rd_idx        = cur_ff;

      case (op)
         DP_LATCH: begin
            cmd_in      = cmd_type'(req_cmd);
            size_in     = req_size_bytes;
            addr_in     = req_address;
            need_in     = req_need;
            r_addr_in   = '0;
            r_size_in   = '0;
            r_moved_in  = 1'b0;
            r_status_in = ST_OK;
         end
         DP_INIT_POOL: begin
            wr_req        = 1'b1;
            wr_idx        = '0;
            wr_len        = NULL_IDX;
            wr_link       = NULL_IDX;
            free_head_in  = '0;
            pool_ready_in = 1'b1;
         end
         DP_LOC_RD: begin
            rd_idx = hh;
         end
         DP_LOC_HDR: begin
            h_in       = hh;
            len_in     = rd_len;
            tgt_h_in   = hh;
            tgt_len_in = rd_len;
         end
         DP_WALK_INIT: begin
            p_in     = NULL_IDX;
            cur_in   = free_head_ff;
            steps_in = '0;
         end
         DP_FF_INIT: begin
            p_in      = NULL_IDX;
            cur_in    = free_head_ff;
            steps_in  = '0;
            take_n_in = need_ff;
         end
         DP_GROW_INIT: begin
            p_in      = NULL_IDX;
            cur_in    = free_head_ff;
            steps_in  = '0;
            tgt_h_in  = h_ff + len_ff;
            take_n_in = need_ff - len_ff;
         end
         DP_WALK_RD: begin
            rd_idx = cur_ff;
         end
         DP_NB_STEP: begin
            p_in     = cur_ff;
            p_len_in = rd_len;
            cur_in   = rd_link;
            steps_in = steps_ff + IDX_W'(1);
         end
         DP_FF_STEP: begin
            c_len_in  = rd_len;
            c_link_in = rd_link;
            if (rd_len < take_n_ff) begin
               p_in     = cur_ff;
               p_len_in = rd_len;
               cur_in   = rd_link;
               steps_in = steps_ff + IDX_W'(1);
            end
         end
         DP_LATCH_C: begin
            c_len_in  = rd_len;
            c_link_in = rd_link;
         end
         // split off the rest of the extent
         DP_TAKE1: begin
            if (c_len_ff > take_n_ff) begin
               wr_req  = 1'b1;
               wr_idx  = cur_ff + take_n_ff;
               wr_len  = c_len_ff - take_n_ff;
               wr_link = c_link_ff;
               nxt_in  = cur_ff + take_n_ff;
            end else begin
               nxt_in  = c_link_ff;
            end
         end
         DP_TAKE2: begin
            if (p_ff == NULL_IDX) begin
               free_head_in = nxt_ff;
            end else begin
               wr_req  = 1'b1;
               wr_idx  = p_ff;
               wr_len  = p_len_ff;
               wr_link = nxt_ff;
            end
         end
         DP_TAKE3: begin
            wr_req  = 1'b1;
            wr_idx  = cur_ff;
            wr_len  = take_n_ff;
            wr_link = cur_ff + IDX_W'(1);
         end
         DP_GROW_CLR: begin
            wr_req = 1'b1;
            wr_idx = cur_ff;
         end
         DP_GROW_H: begin
            wr_req    = 1'b1;
            wr_idx    = h_ff;
            wr_len    = len_ff + take_n_ff;
            wr_link   = h_ff + IDX_W'(1);
            r_addr_in = addr_ff;
         end
         DP_SHR_WR: begin
            wr_req     = 1'b1;
            wr_idx     = h_ff + need_ff;
            wr_len     = len_ff - need_ff;
            wr_link    = h_ff + need_ff + IDX_W'(1);
            tgt_h_in   = h_ff + need_ff;
            tgt_len_in = len_ff - need_ff;
         end
         DP_SHR_FIN: begin
            wr_req    = 1'b1;
            wr_idx    = h_ff;
            wr_len    = need_ff;
            wr_link   = h_ff + IDX_W'(1);
            r_addr_in = addr_ff;
         end
         DP_RES_ALLOC: begin
            r_addr_in = cur_bytes[FIELD_W-1:0];
         end
         DP_RES_MOVE: begin
            r_addr_in  = cur_bytes[FIELD_W-1:0];
            r_size_in  = (BYTE_W'(size_ff) < old_bytes) ? size_ff : old_bytes[FIELD_W-1:0];
            r_moved_in = 1'b1;
            tgt_h_in   = h_ff;
            tgt_len_in = len_ff;
         end
         DP_RES_SAME: begin
            r_addr_in = addr_ff;
         end
         DP_RES_QUERY: begin
            r_size_in = old_bytes[FIELD_W-1:0];
         end
         // insert a free extent between p and after
         DP_INS_PUT_H: begin
            wr_req      = 1'b1;
            wr_idx      = tgt_h_ff;
            wr_len      = tgt_len_ff;
            wr_link     = after;
            ins_link_in = after;
         end
         DP_INS_PREV: begin
            rd_idx = after;
            if (p_ff == NULL_IDX) begin
               free_head_in = tgt_h_ff;
            end else begin
               wr_req  = 1'b1;
               wr_idx  = p_ff;
               wr_len  = p_len_ff;
               wr_link = tgt_h_ff;
            end
         end
         DP_INS_AFT: begin
            wr_req      = 1'b1;
            wr_idx      = tgt_h_ff;
            wr_len      = tgt_len_ff + rd_len;
            wr_link     = rd_link;
            tgt_len_in  = tgt_len_ff + rd_len;
            ins_link_in = rd_link;
         end
         DP_INS_AFT_CLR: begin
            wr_req = 1'b1;
            wr_idx = after;
         end
         DP_INS_PRV: begin
            wr_req  = 1'b1;
            wr_idx  = p_ff;
            wr_len  = p_len_ff + tgt_len_ff;
            wr_link = ins_link_ff;
         end
         DP_INS_PRV_CLR: begin
            wr_req = 1'b1;
            wr_idx = tgt_h_ff;
         end
         DP_ST_BAD: begin
            r_status_in = ST_BAD_ADDR;
         end
         DP_ST_NOSPACE: begin
            r_status_in = ST_NO_SPACE;
         end
         DP_ST_NOTREADY: begin
            r_status_in = ST_NOT_READY;
         end
         DP_EMIT: begin
            out_addr_in   = r_addr_ff;
            out_size_in   = r_size_ff;
            out_moved_in  = r_moved_ff;
            out_status_in = r_status_ff;
         end
         default: begin
         end
      endcase
   end

   // writes beyond the pool are dropped
   assign wr_en = wr_req && (wr_idx < NULL_IDX);

   ffca_ram #(
      .WIDTH(WORD_W),
      .DEPTH(POOL_CHUNKS)
   ) u_hdr_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_idx[ADDR_W-1:0]),
      .wr_data({wr_len, wr_link}),
      .rd_addr(rd_idx[ADDR_W-1:0]),
      .rd_data(rd_word)
   );

   // pool state
   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff  <= NULL_IDX;
         pool_ready_ff <= 1'b0;
      end else begin
         free_head_ff  <= free_head_in;
         pool_ready_ff <= pool_ready_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      need_ff       <= need_in;
      h_ff          <= h_in;
      len_ff        <= len_in;
      tgt_h_ff      <= tgt_h_in;
      tgt_len_ff    <= tgt_len_in;
      p_ff          <= p_in;
      p_len_ff      <= p_len_in;
      cur_ff        <= cur_in;
      steps_ff      <= steps_in;
      c_len_ff      <= c_len_in;
      c_link_ff     <= c_link_in;
      take_n_ff     <= take_n_in;
      nxt_ff        <= nxt_in;
      ins_link_ff   <= ins_link_in;
      r_addr_ff     <= r_addr_in;
      r_size_ff     <= r_size_in;
      r_moved_ff    <= r_moved_in;
      r_status_ff   <= r_status_in;
      out_addr_ff   <= out_addr_in;
      out_size_ff   <= out_size_in;
      out_moved_ff  <= out_moved_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_result_address = out_addr_ff;
   assign rsp_result_size    = out_size_ff;
   assign rsp_moved          = out_moved_ff;
   assign rsp_status         = out_status_ff;

   // the pool stays set up once the first alloc arrived
   a_ready_sticky: assert property (@(posedge clock) disable iff (reset)
      pool_ready_ff |=> pool_ready_ff)
      else $error("pool ready flag dropped");

   // the free list is empty until the pool is set up
   a_head_null: assert property (@(posedge clock) disable iff (reset)
      !pool_ready_ff |-> (free_head_ff == NULL_IDX))
      else $error("free list head set before pool setup");

endmodule

[hw/rtl/ffca_ctrl.sv]
// Controller of the allocator: sequences the datapath micro-operations.
// Depends on ffca_pkg; drives ffca_dp through an op code, reads its flags.
`timescale 1ns / 1ps

module ffca_ctrl
   import ffca_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_noop_free,
   input  dp_flags_type flags,
   output dp_op_type    op
);

   typedef enum logic [5:0] {
      S_IDLE, S_DISPATCH, S_INIT, S_LOC_RD, S_LOC_HDR, S_WALK_INIT, S_NB_WALK,
      S_NB_STEP, S_NB_CHECK, S_RS_DECIDE, S_SHR_WR, S_SHR_FIN, S_GROW_RD,
      S_GROW_CHK, S_FF_INIT, S_FF_WALK, S_FF_STEP, S_TAKE1, S_TAKE2, S_TAKE3,
      S_RES_ALLOC, S_RES_MOVE, S_GROW_CLR, S_GROW_H, S_INS_PUT_H, S_INS_PREV,
      S_INS_AFT, S_INS_AFT_CLR, S_INS_PRV_M, S_INS_PRV_CLR, S_INS_END, S_BAD,
      S_NOSPACE, S_DONE
   } state_type;

   // what a neighbor walk, an insert and a take return to
   typedef enum logic [1:0] {NB_LOC, NB_INS, NB_GROW} nb_ctx_type;
   typedef enum logic [1:0] {INS_FREE, INS_SHRINK, INS_MOVE} ins_ctx_type;
   typedef enum logic [1:0] {TK_ALLOC, TK_GROW, TK_MOVE} tk_ctx_type;

   state_type   state_ff, state_in;
   nb_ctx_type  nb_ff, nb_in;
   ins_ctx_type ins_ff, ins_in;
   tk_ctx_type  tk_ff, tk_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        noop_ff, noop_in;
   logic        emit;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign noop_in   = csr_valid ? csr_noop_free : noop_ff;

   // next state and datapath op
   always_comb begin
      state_in = state_ff;
      nb_in    = nb_ff;
      ins_in   = ins_ff;
      tk_in    = tk_ff;
      op       = DP_NOP;
      emit     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op       = DP_LATCH;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (flags.cmd == CMD_ALLOC) begin
               tk_in    = TK_ALLOC;
               state_in = flags.pool_ready ? S_FF_INIT : S_INIT;
            end else if (!flags.pool_ready) begin
               op       = DP_ST_NOTREADY;
               state_in = S_DONE;
            end else if ((flags.cmd == CMD_FREE) && noop_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_LOC_RD;
            end
         end
         S_INIT: begin
            op       = DP_INIT_POOL;
            state_in = S_FF_INIT;
         end
         S_LOC_RD: begin
            if (flags.loc_bad_addr) begin
               state_in = S_BAD;
            end else begin
               op       = DP_LOC_RD;
               state_in = S_LOC_HDR;
            end
         end
         S_LOC_HDR: begin
            op       = DP_LOC_HDR;
            nb_in    = NB_LOC;
            state_in = flags.hdr_bad ? S_BAD : S_WALK_INIT;
         end
         S_WALK_INIT: begin
            op       = DP_WALK_INIT;
            state_in = S_NB_WALK;
         end
         S_NB_WALK: begin
            if (flags.walk_nb_go) begin
               op       = DP_WALK_RD;
               state_in = S_NB_STEP;
            end else begin
               state_in = S_NB_CHECK;
            end
         end
         S_NB_STEP: begin
            op       = DP_NB_STEP;
            state_in = S_NB_WALK;
         end
         S_NB_CHECK: begin
            case (nb_ff)
               NB_LOC: begin
                  if (!flags.nb_ok) begin
                     state_in = S_BAD;
                  end else if (flags.cmd == CMD_FREE) begin
                     ins_in   = INS_FREE;
                     state_in = S_INS_PUT_H;
                  end else if (flags.cmd == CMD_QUERY) begin
                     op       = DP_RES_QUERY;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_RS_DECIDE;
                  end
               end
               NB_INS: begin
                  state_in = flags.nb_ok ? S_INS_PUT_H : S_INS_END;
               end
               default: begin
                  if (flags.grow_hit) begin
                     state_in = S_GROW_RD;
                  end else begin
                     tk_in    = TK_MOVE;
                     state_in = S_FF_INIT;
                  end
               end
            endcase
         end
         S_RS_DECIDE: begin
            if (flags.need_eq) begin
               op       = DP_RES_SAME;
               state_in = S_DONE;
            end else if (flags.need_lt) begin
               state_in = S_SHR_WR;
            end else begin
               op       = DP_GROW_INIT;
               nb_in    = NB_GROW;
               state_in = S_NB_WALK;
            end
         end
         S_SHR_WR: begin
            op       = DP_SHR_WR;
            nb_in    = NB_INS;
            ins_in   = INS_SHRINK;
            state_in = S_WALK_INIT;
         end
         S_SHR_FIN: begin
            op       = DP_SHR_FIN;
            state_in = S_DONE;
         end
         S_GROW_RD: begin
            op       = DP_WALK_RD;
            state_in = S_GROW_CHK;
         end
         S_GROW_CHK: begin
            op = DP_LATCH_C;
            if (flags.fit) begin
               tk_in    = TK_GROW;
               state_in = S_TAKE1;
            end else begin
               tk_in    = TK_MOVE;
               state_in = S_FF_INIT;
            end
         end
         S_FF_INIT: begin
            op       = DP_FF_INIT;
            state_in = S_FF_WALK;
         end
         S_FF_WALK: begin
            if (flags.walk_ff_go) begin
               op       = DP_WALK_RD;
               state_in = S_FF_STEP;
            end else begin
               state_in = S_NOSPACE;
            end
         end
         S_FF_STEP: begin
            op       = DP_FF_STEP;
            state_in = flags.fit ? S_TAKE1 : S_FF_WALK;
         end
         S_TAKE1: begin
            op       = DP_TAKE1;
            state_in = S_TAKE2;
         end
         S_TAKE2: begin
            op       = DP_TAKE2;
            state_in = S_TAKE3;
         end
         S_TAKE3: begin
            op = DP_TAKE3;
            case (tk_ff)
               TK_ALLOC: state_in = S_RES_ALLOC;
               TK_GROW:  state_in = S_GROW_CLR;
               default:  state_in = S_RES_MOVE;
            endcase
         end
         S_RES_ALLOC: begin
            op       = DP_RES_ALLOC;
            state_in = S_DONE;
         end
         S_RES_MOVE: begin
            op       = DP_RES_MOVE;
            nb_in    = NB_INS;
            ins_in   = INS_MOVE;
            state_in = noop_ff ? S_DONE : S_WALK_INIT;
         end
         S_GROW_CLR: begin
            op       = DP_GROW_CLR;
            state_in = S_GROW_H;
         end
         S_GROW_H: begin
            op       = DP_GROW_H;
            state_in = S_DONE;
         end
         S_INS_PUT_H: begin
            op       = DP_INS_PUT_H;
            state_in = S_INS_PREV;
         end
         S_INS_PREV: begin
            op       = DP_INS_PREV;
            state_in = S_INS_AFT;
         end
         S_INS_AFT: begin
            if (flags.merge_after) begin
               op       = DP_INS_AFT;
               state_in = S_INS_AFT_CLR;
            end else begin
               state_in = S_INS_PRV_M;
            end
         end
         S_INS_AFT_CLR: begin
            op       = DP_INS_AFT_CLR;
            state_in = S_INS_PRV_M;
         end
         S_INS_PRV_M: begin
            if (flags.merge_prev) begin
               op       = DP_INS_PRV;
               state_in = S_INS_PRV_CLR;
            end else begin
               state_in = S_INS_END;
            end
         end
         S_INS_PRV_CLR: begin
            op       = DP_INS_PRV_CLR;
            state_in = S_INS_END;
         end
         S_INS_END: begin
            state_in = (ins_ff == INS_SHRINK) ? S_SHR_FIN : S_DONE;
         end
         S_BAD: begin
            op       = DP_ST_BAD;
            state_in = S_DONE;
         end
         S_NOSPACE: begin
            op       = DP_ST_NOSPACE;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               op       = DP_EMIT;
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   // state, contexts, result valid and config register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nb_ff        <= NB_LOC;
         ins_ff       <= INS_FREE;
         tk_ff        <= TK_ALLOC;
         rsp_valid_ff <= 1'b0;
         noop_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nb_ff        <= nb_in;
         ins_ff       <= ins_in;
         tk_ff        <= tk_in;
         rsp_valid_ff <= rsp_valid_in;
         noop_ff      <= noop_in;
      end
   end

   // a pending result is never overwritten
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && rsp_stall) |=> (state_ff == S_DONE))
      else $error("result slot overwritten");

   // a result only appears on completion of a transaction
   a_valid_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result valid without completion");

   // an accepted transaction is dispatched next
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && state_ff == S_IDLE) |=> (state_ff == S_DISPATCH))
      else $error("accepted transaction not dispatched");

endmodule

[hw/rtl/first_fit_chunk_allocator_unit.sv]
// Top level of the first-fit chunk allocator: controller plus datapath.
// Depends on ffca_pkg, ffca_ctrl, ffca_dp (which holds ffca_ram).
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_cmd, req_size_bytes, req_address
//   rsp      out        rsp_valid / rsp_stall  rsp_result_address, rsp_result_size,
//                                              rsp_moved, rsp_status
//   csr      in         csr_valid / csr_ready  csr_noop_free
//
// One transaction at a time; the free list is walked one link at a time
// (registered read of the single header RAM). An alloc walks the free list once,
// after setting up the pool on the first alloc; a free walks the free extents
// below the header; a resize takes up to four walks. Synchronous active-high
// reset; the header RAM needs no clearing pass. A new transaction is taken
// while the previous result is stalled.
`timescale 1ns / 1ps

module first_fit_chunk_allocator_unit
   import ffca_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [FIELD_W-1:0] req_size_bytes,
   input  logic [FIELD_W-1:0] req_address,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [FIELD_W-1:0] rsp_result_address,
   output logic [FIELD_W-1:0] rsp_result_size,
   output logic               rsp_moved,
   output logic [1:0]         rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_noop_free
);

   dp_op_type    op;
   dp_flags_type flags;

   // sequencer
   ffca_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_noop_free(csr_noop_free),
      .flags        (flags),
      .op           (op)
   );

   // list walk, header store and results
   ffca_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .op                (op),
      .req_cmd           (req_cmd),
      .req_size_bytes    (req_size_bytes),
      .req_address       (req_address),
      .flags             (flags),
      .rsp_result_address(rsp_result_address),
      .rsp_result_size   (rsp_result_size),
      .rsp_moved         (rsp_moved),
      .rsp_status        (rsp_status)
   );

endmodule

[verif/first_fit_chunk_allocator_unit_tb.sv]
// Self-checking testbench for first_fit_chunk_allocator_unit: tracks the free list and
// reservations on its own and checks every response. Depends on ffca_pkg and the RTL top.
`timescale 1ns / 1ps

module first_fit_chunk_allocator_unit_tb;
   import ffca_pkg::*;

   localparam int unsigned NIL       = POOL_CHUNKS;
   localparam int          CYCLE_CAP = 6_000_000;

   typedef struct {
      logic [FIELD_W-1:0] addr;
      logic [FIELD_W-1:0] size;
      logic               moved;
      status_type         status;
   } alloc_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_cmd = '0;
   logic [FIELD_W-1:0] req_size_bytes = '0;
   logic [FIELD_W-1:0] req_address = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [FIELD_W-1:0] rsp_result_address;
   logic [FIELD_W-1:0] rsp_result_size;
   logic               rsp_moved;
   logic [1:0]         rsp_status;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_noop_free = 1'b0;

   first_fit_chunk_allocator_unit u_top (.*);

   always #5 clock = ~clock;

   // shadow allocator state
   int unsigned hdr_len [POOL_CHUNKS];
   int unsigned hdr_link[POOL_CHUNKS];
   bit          hdr_written[POOL_CHUNKS];
   int unsigned head_idx = NIL;
   bit          pool_up = 1'b0;
   bit          free_is_noop = 1'b0;

   alloc_result_type pending_results[$];
   int unsigned      live_chunks[$];
   int               mismatches = 0;
   int               cycles = 0;
   int               send_gap_pct = 0;
   int               stall_pct = 0;

   function automatic int unsigned len_at(int unsigned i);
      return i < NIL ? hdr_len[i] : 0;
   endfunction

   function automatic int unsigned link_at(int unsigned i);
      return i < NIL ? hdr_link[i] : NIL;
   endfunction

   function automatic void put_hdr(int unsigned i, int unsigned len, int unsigned lnk);
      if (i < NIL) begin
         hdr_len[i] = len;
         hdr_link[i] = lnk;
         hdr_written[i] = 1'b1;
      end
   endfunction

   // unlink extent cur, keep need chunks, leave the rest on the list
   function automatic void carve(int unsigned prev, int unsigned cur, int unsigned need);
      int unsigned nxt;
      int unsigned have;
      nxt = link_at(cur);
      have = len_at(cur);
      if (have > need) begin
         put_hdr(cur + need, have - need, nxt);
         nxt = cur + need;
      end
      if (prev == NIL) head_idx = nxt;
      else put_hdr(prev, len_at(prev), nxt);
      put_hdr(cur, need, cur + 1);
   endfunction

   function automatic bit first_fit(int unsigned need, output int unsigned at);
      int unsigned prev;
      int unsigned cur;
      int unsigned steps;
      prev = NIL;
      cur = head_idx;
      steps = 0;
      at = 0;
      while (cur < NIL && steps < NIL) begin
         if (len_at(cur) >= need) begin
            carve(prev, cur, need);
            at = cur;
            return 1'b1;
         end
         prev = cur;
         cur = link_at(cur);
         steps++;
      end
      return 1'b0;
   endfunction

   function automatic bit find_neighbours(int unsigned h, int unsigned len,
                                          output int unsigned p, output int unsigned aft);
      int unsigned cur;
      int unsigned steps;
      p = NIL;
      cur = head_idx;
      steps = 0;
      while (cur < h && steps < NIL) begin
         p = cur;
         cur = link_at(cur);
         steps++;
      end
      if (cur > NIL) cur = NIL;
      aft = cur;
      if (p != NIL && p + len_at(p) > h) return 1'b0;
      if (cur != NIL && cur < h + len) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void release_extent(int unsigned h, int unsigned len);
      int unsigned p;
      int unsigned aft;
      if (!find_neighbours(h, len, p, aft)) return;
      put_hdr(h, len, aft);
      if (p == NIL) head_idx = h;
      else put_hdr(p, len_at(p), h);
      if (aft != NIL && h + len == aft) begin
         put_hdr(h, len + len_at(aft), link_at(aft));
         put_hdr(aft, 0, 0);
      end
      if (p != NIL && p + len_at(p) == h) begin
         put_hdr(p, len_at(p) + len_at(h), link_at(h));
         put_hdr(h, 0, 0);
      end
   endfunction

   function automatic bit find_reservation(int unsigned addr, output int unsigned h,
                                           output int unsigned len);
      int unsigned chunk;
      int unsigned p;
      int unsigned aft;
      chunk = addr / CHUNK_BYTES;
      h = 0;
      len = 0;
      if (chunk == 0 || chunk >= NIL) return 1'b0;
      h = chunk - 1;
      len = len_at(h);
      if (len < 1 || len > NIL - h) return 1'b0;
      if (link_at(h) != h + 1) return 1'b0;
      if (!find_neighbours(h, len, p, aft)) return 1'b0;
      return 1'b1;
   endfunction

   function automatic int unsigned chunks_needed(int unsigned bytes);
      return (bytes + CHUNK_BYTES - 1) / CHUNK_BYTES + 1;
   endfunction

   // expected response for one command, updating the shadow state
   function automatic alloc_result_type predict_alloc(cmd_type cmd, int unsigned size,
                                                      int unsigned addr);
      alloc_result_type r;
      int unsigned   h, len, at, need, target, add, prev, cur, steps, old_bytes;
      bit            done;
      int unsigned   ra, rs;
      ra = 0;
      rs = 0;
      r.moved = 1'b0;
      r.status = ST_OK;
      if (cmd == CMD_ALLOC) begin
         if (!pool_up) begin
            put_hdr(0, NIL, NIL);
            head_idx = 0;
            pool_up = 1'b1;
         end
         if (first_fit(chunks_needed(size), at)) ra = (at + 1) * CHUNK_BYTES;
         else r.status = ST_NO_SPACE;
      end else if (!pool_up) begin
         r.status = ST_NOT_READY;
      end else if (cmd == CMD_FREE) begin
         if (free_is_noop) r.status = ST_OK;
         else if (!find_reservation(addr, h, len)) r.status = ST_BAD_ADDR;
         else release_extent(h, len);
      end else if (cmd == CMD_QUERY) begin
         if (!find_reservation(addr, h, len)) r.status = ST_BAD_ADDR;
         else rs = (len - 1) * CHUNK_BYTES;
      end else if (!find_reservation(addr, h, len)) begin
         r.status = ST_BAD_ADDR;
      end else begin
         need = chunks_needed(size);
         done = 1'b0;
         if (need == len) begin
            done = 1'b1;
         end else if (need < len) begin
            // shrink in place, tail goes back to the list
            put_hdr(h, len, h + 1);
            put_hdr(h + need, len - need, h + need + 1);
            release_extent(h + need, len - need);
            put_hdr(h, need, h + 1);
            done = 1'b1;
         end else begin
            // try to grow into the free extent right after
            target = h + len;
            add = need - len;
            prev = NIL;
            cur = head_idx;
            steps = 0;
            while (cur < target && steps < NIL) begin
               prev = cur;
               cur = link_at(cur);
               steps++;
            end
            if (cur == target && cur < NIL && len_at(cur) >= add) begin
               carve(prev, cur, add);
               put_hdr(cur, 0, 0);
               put_hdr(h, len + add, h + 1);
               done = 1'b1;
            end
         end
         if (done) begin
            ra = addr;
         end else if (first_fit(need, at)) begin
            old_bytes = (len - 1) * CHUNK_BYTES;
            ra = (at + 1) * CHUNK_BYTES;
            rs = size < old_bytes ? size : old_bytes;
            r.moved = 1'b1;
            if (!free_is_noop) release_extent(h, len);
         end else begin
            r.status = ST_NO_SPACE;
         end
      end
      r.addr = ra[FIELD_W-1:0];
      r.size = rs[FIELD_W-1:0];
      return r;
   endfunction

   function automatic void drop_live(int unsigned chunk);
      foreach (live_chunks[i])
         if (live_chunks[i] == chunk) begin
            live_chunks.delete(i);
            return;
         end
   endfunction

   // an address whose header slot was never written must not be presented
   function automatic bit addr_is_safe(int unsigned addr);
      int unsigned chunk;
      chunk = addr / CHUNK_BYTES;
      return !pool_up || chunk == 0 || hdr_written[chunk - 1];
   endfunction

   // drive one transaction and wait for it to be taken
   task automatic send_cmd(cmd_type cmd, int unsigned size, int unsigned addr);
      alloc_result_type r;
      if (cmd != CMD_ALLOC && !addr_is_safe(addr[FIELD_W-1:0])) return;
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_size_bytes <= size[FIELD_W-1:0];
      req_address <= addr[FIELD_W-1:0];
      do @(posedge clock); while (req_stall);
      r = predict_alloc(cmd, size[FIELD_W-1:0], addr[FIELD_W-1:0]);
      pending_results.push_back(r);
      if (r.status == ST_OK) begin
         if (cmd == CMD_ALLOC && r.addr != 0) live_chunks.push_back(r.addr / CHUNK_BYTES);
         if (cmd == CMD_FREE && !free_is_noop) drop_live(addr[FIELD_W-1:0] / CHUNK_BYTES);
         if (cmd == CMD_RESIZE && r.moved) begin
            if (!free_is_noop) drop_live(addr[FIELD_W-1:0] / CHUNK_BYTES);
            if (r.addr != 0) live_chunks.push_back(r.addr / CHUNK_BYTES);
         end
      end
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_noop_free(bit value);
      drain_results();
      csr_valid <= 1'b1;
      csr_noop_free <= value;
      do @(posedge clock); while (!csr_ready);
      free_is_noop = value;
      csr_valid <= 1'b0;
   endtask

   // response checker
   always @(posedge clock) begin
      alloc_result_type e;
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response addr=%0d", rsp_result_address);
         end else begin
            e = pending_results.pop_front();
            if (rsp_result_address !== e.addr || rsp_result_size !== e.size ||
                rsp_moved !== e.moved || rsp_status !== e.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp addr=%0d size=%0d moved=%0b st=%0d, got %0d %0d %0b %0d",
                           e.addr, e.size, e.moved, e.status, rsp_result_address,
                           rsp_result_size, rsp_moved, rsp_status);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // commands before the pool exists, then its first setup
   task automatic test_not_ready();
      send_cmd(CMD_FREE, 0, 16'h3FFF);
      send_cmd(CMD_RESIZE, 16'h3FFF, 32);
      send_cmd(CMD_QUERY, 0, 16);
      send_cmd(CMD_ALLOC, 16'h3FFF, 0);
   endtask

   // extremes, shrink, grow, move, double free, bad headers
   task automatic test_directed();
      send_cmd(CMD_ALLOC, 0, 0);
      send_cmd(CMD_ALLOC, 100, 0);
      send_cmd(CMD_ALLOC, 16, 0);
      send_cmd(CMD_QUERY, 0, 32);
      send_cmd(CMD_QUERY, 0, 16 + 15);
      send_cmd(CMD_RESIZE, 40, 32);
      send_cmd(CMD_RESIZE, 100, 32);
      send_cmd(CMD_FREE, 0, 15);
      send_cmd(CMD_FREE, 0, 16);
      send_cmd(CMD_FREE, 0, 16);
      send_cmd(CMD_RESIZE, 5000, 48);
      send_cmd(CMD_QUERY, 0, 0);
      send_cmd(CMD_ALLOC, 16368 - 16 * 40, 0);
      send_cmd(CMD_ALLOC, 16383, 0);
      send_cmd(CMD_RESIZE, 0, 32);
      send_cmd(CMD_RESIZE, 16383, 48);
   endtask

   task automatic test_random(int n_items, int gap, int stall);
      int unsigned r, addr, size, pick;
      send_gap_pct = gap;
      stall_pct = stall;
      repeat (n_items) begin
         r = $urandom_range(99);
         size = ($urandom_range(19) == 0) ? $urandom_range(16383) : $urandom_range(600);
         if (live_chunks.size() != 0 && $urandom_range(9) != 0) begin
            pick = $urandom_range(live_chunks.size() - 1);
            addr = live_chunks[pick] * CHUNK_BYTES + $urandom_range(CHUNK_BYTES - 1);
         end else begin
            do addr = $urandom_range(16383); while (!addr_is_safe(addr));
         end
         if (live_chunks.size() > 40 && r < 40) r = r + 35;
         if (r < 35) send_cmd(CMD_ALLOC, size, $urandom_range(16383));
         else if (r < 62) send_cmd(CMD_FREE, $urandom_range(16383), addr);
         else if (r < 82) send_cmd(CMD_RESIZE, size, addr);
         else send_cmd(CMD_QUERY, $urandom_range(16383), addr);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_not_ready();
      test_directed();
      write_noop_free(1'b1);
      test_directed();
      write_noop_free(1'b0);
      test_random(400, 0, 0);
      test_random(350, 64, 0);
      write_noop_free(1'b1);
      test_random(150, 0, 64);
      write_noop_free(1'b0);
      test_random(350, 0, 64);
      test_random(300, 30, 30);
      drain_results();
      if (mismatches == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
